// ===== rtl/core/cdsa_pkg.sv =====
// Package with widths, constants and the month length table of the date core.
`default_nettype none
package cdsa_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int MAX_YEAR    = 9999;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int OFFSET_W = 16;
   localparam int YEXT_W   = YEAR_W + 1;
   localparam int DACC_W   = OFFSET_BITS + 2;

   localparam int RECIP       = 5243;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam int CENT_W      = 8;

   localparam logic REQ_SET = 1'b0;
   localparam logic REQ_ADD = 1'b1;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
   localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
   localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;

   localparam logic [DAY_W-1:0] DEC_DAYS = 5'd31;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] days;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
         MONTH_FEB: days = leap ? 5'd29 : 5'd28;
         default: days = 5'd0;
      endcase
      return days;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cdsa_chan_if.sv =====
// Request and response channel interfaces of the date core.
`default_nettype none
interface cdsa_req_if;
   logic                              valid;
   logic                              ready;
   logic                              req_type;
   logic [cdsa_pkg::DAY_W-1:0]        new_day;
   logic [cdsa_pkg::MONTH_W-1:0]      new_month;
   logic [cdsa_pkg::YEAR_W-1:0]       new_year;
   logic signed [cdsa_pkg::OFFSET_W-1:0] day_offset;

   modport source (output valid, req_type, new_day, new_month, new_year, day_offset,
                   input ready);
   modport sink (input valid, req_type, new_day, new_month, new_year, day_offset,
                 output ready);
endinterface

interface cdsa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cdsa_pkg::DAY_W-1:0]   cur_day;
   logic [cdsa_pkg::MONTH_W-1:0] cur_month;
   logic [cdsa_pkg::YEAR_W-1:0]  cur_year;
   logic                         rejected;

   modport source (output valid, cur_day, cur_month, cur_year, rejected, input ready);
   modport sink (input valid, cur_day, cur_month, cur_year, rejected, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/calendar_date_set_and_add_days_core.sv =====
// Top level of the Gregorian date core with validated set and signed day add.
// A set request passes through the leap and step states to the response word.
// An add request walks one month per cycle through a shared compare and add or subtract
// step, pausing in the leap state for the leap test of each year crossed. One request is
// in flight at a time, and the next one can be taken in the cycle after the response
// word leaves.
// Synchronous reset loads the date 2000-01-01 and empties the sequencer.
`default_nettype none
module calendar_date_set_and_add_days_core (
   input  logic       clock,
   input  logic       reset,
   cdsa_req_if.sink   req_chan,
   cdsa_rsp_if.source rsp_chan
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LEAP = 4'b0010,
      ST_STEP = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic op_ff, op_in;
   logic rej_ff, rej_in;
   logic [cdsa_pkg::DAY_W-1:0]   day_ff, day_in;
   logic [cdsa_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [cdsa_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic signed [cdsa_pkg::DACC_W-1:0] dacc_ff, dacc_in;
   logic [cdsa_pkg::MONTH_W-1:0] mwalk_ff, mwalk_in;
   logic [cdsa_pkg::YEXT_W-1:0]  ywalk_ff, ywalk_in;
   logic [cdsa_pkg::CENT_W-1:0]  cent_ff, cent_in;

   logic [cdsa_pkg::OFFSET_BITS-1:0] off_raw;
   logic signed [cdsa_pkg::DACC_W-1:0] off_ext;
   logic [cdsa_pkg::YEXT_W+cdsa_pkg::RECIP_W-1:0] recip_prod;
   logic [cdsa_pkg::YEXT_W-1:0] cent_x100;
   logic is_century, is_leap, under, over, set_ok;
   logic [cdsa_pkg::MONTH_W-1:0] look_month;
   logic [cdsa_pkg::DAY_W-1:0] lim;
   logic signed [cdsa_pkg::DACC_W-1:0] lim_ext;

   assign off_raw = cdsa_pkg::OFFSET_BITS'(req_chan.day_offset);
   assign off_ext = cdsa_pkg::DACC_W'(signed'(off_raw));

   // Year divided by 100 through a reciprocal multiply, exact below 16384.
   assign recip_prod = (cdsa_pkg::YEXT_W+cdsa_pkg::RECIP_W)'(ywalk_ff)
                     * (cdsa_pkg::YEXT_W+cdsa_pkg::RECIP_W)'(cdsa_pkg::RECIP);
   assign cent_in = cdsa_pkg::CENT_W'(recip_prod >> cdsa_pkg::RECIP_SHIFT);

   assign cent_x100 = (cdsa_pkg::YEXT_W'(cent_ff) << 6) + (cdsa_pkg::YEXT_W'(cent_ff) << 5)
                    + (cdsa_pkg::YEXT_W'(cent_ff) << 2);
   assign is_century = (ywalk_ff == cent_x100);
   assign is_leap = (ywalk_ff[1:0] == 2'b00) && (!is_century || cent_ff[1:0] == 2'b00);

   assign under = dacc_ff[cdsa_pkg::DACC_W-1] || (dacc_ff == '0);
   assign look_month = (op_ff == cdsa_pkg::REQ_ADD && under) ? mwalk_ff - 1'b1 : mwalk_ff;
   assign lim = cdsa_pkg::month_days(look_month, is_leap);
   assign lim_ext = signed'({{(cdsa_pkg::DACC_W-cdsa_pkg::DAY_W){1'b0}}, lim});
   assign over = dacc_ff > lim_ext;
   assign set_ok = (ywalk_ff <= cdsa_pkg::YEXT_W'(cdsa_pkg::MAX_YEAR)) && (lim != '0)
                 && !under && !over;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      rej_in   = rej_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      dacc_in  = dacc_ff;
      mwalk_in = mwalk_ff;
      ywalk_in = ywalk_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.req_type;
               rej_in   = 1'b0;
               state_in = ST_LEAP;
               if (req_chan.req_type == cdsa_pkg::REQ_SET) begin
                  dacc_in  = cdsa_pkg::DACC_W'(req_chan.new_day);
                  mwalk_in = req_chan.new_month;
                  ywalk_in = cdsa_pkg::YEXT_W'(req_chan.new_year);
               end else begin
                  dacc_in  = cdsa_pkg::DACC_W'(day_ff) + off_ext;
                  mwalk_in = month_ff;
                  ywalk_in = cdsa_pkg::YEXT_W'(year_ff);
               end
            end
         end
         ST_LEAP: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (op_ff == cdsa_pkg::REQ_SET) begin
               state_in = ST_DONE;
               if (set_ok) begin
                  day_in   = cdsa_pkg::DAY_W'(dacc_ff);
                  month_in = mwalk_ff;
                  year_in  = cdsa_pkg::YEAR_W'(ywalk_ff);
               end else begin
                  rej_in = 1'b1;
               end
            end else if (over) begin
               dacc_in = dacc_ff - lim_ext;
               if (mwalk_ff == cdsa_pkg::MONTH_DEC) begin
                  mwalk_in = cdsa_pkg::MONTH_JAN;
                  ywalk_in = ywalk_ff + 1'b1;
                  if (ywalk_ff >= cdsa_pkg::YEXT_W'(cdsa_pkg::MAX_YEAR)) begin
                     rej_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_LEAP;
                  end
               end else begin
                  mwalk_in = mwalk_ff + 1'b1;
               end
            end else if (under) begin
               if (mwalk_ff == cdsa_pkg::MONTH_JAN) begin
                  if (ywalk_ff == '0) begin
                     rej_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     // December always has 31 days, so the new year's leap test can wait.
                     ywalk_in = ywalk_ff - 1'b1;
                     mwalk_in = cdsa_pkg::MONTH_DEC;
                     dacc_in  = dacc_ff + cdsa_pkg::DACC_W'(cdsa_pkg::DEC_DAYS);
                     state_in = ST_LEAP;
                  end
               end else begin
                  mwalk_in = mwalk_ff - 1'b1;
                  dacc_in  = dacc_ff + lim_ext;
               end
            end else begin
               day_in   = cdsa_pkg::DAY_W'(dacc_ff);
               month_in = mwalk_ff;
               year_in  = cdsa_pkg::YEAR_W'(ywalk_ff);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rej_ff   <= 1'b0;
         day_ff   <= cdsa_pkg::RESET_DAY;
         month_ff <= cdsa_pkg::RESET_MONTH;
         year_ff  <= cdsa_pkg::RESET_YEAR;
      end else begin
         state_ff <= state_in;
         rej_ff   <= rej_in;
         day_ff   <= day_in;
         month_ff <= month_in;
         year_ff  <= year_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      dacc_ff  <= dacc_in;
      mwalk_ff <= mwalk_in;
      ywalk_ff <= ywalk_in;
      cent_ff  <= cent_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = (state_ff == ST_DONE);
   assign rsp_chan.cur_day   = day_ff;
   assign rsp_chan.cur_month = month_ff;
   assign rsp_chan.cur_year  = year_ff;
   assign rsp_chan.rejected  = rej_ff;

endmodule
`default_nettype wire

// ===== rtl/core/cdsa_checker.sv =====
// Port-level checker of the date core and its bind to the top level.
`default_nettype none
module cdsa_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [cdsa_pkg::DAY_W-1:0]   cur_day,
   input wire logic [cdsa_pkg::MONTH_W-1:0] cur_month,
   input wire logic [cdsa_pkg::YEAR_W-1:0]  cur_year
);

   // A word on the response side stays until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped before it was taken");

   // No new request is taken while a response word is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   // An accepted request is never answered in the very next cycle, and no other request is taken then.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("request answered without working");

   // A reported date always has a month from 1 to 12, a day of at least 1 and a year of at most 9999.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cur_month >= 4'd1 && cur_month <= 4'd12 && cur_day >= 5'd1
         && cur_year <= cdsa_pkg::YEAR_W'(cdsa_pkg::MAX_YEAR))
      else $error("reported date out of range");

endmodule

bind calendar_date_set_and_add_days_core cdsa_checker u_cdsa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .cur_day   (rsp_chan.cur_day),
   .cur_month (rsp_chan.cur_month),
   .cur_year  (rsp_chan.cur_year)
);
`default_nettype wire

// ===== tb/calendar_date_set_and_add_days_core_test.sv =====
// Self-checking testbench of the date core: directed table, then random set and add words.
`timescale 1ns / 100ps
module calendar_date_set_and_add_days_core_test;

   localparam int RANDOM_WORDS = 400;
   localparam int STEADY_WORDS = 60;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int DRAIN_CYCLES = 20;

   localparam logic OP_SET = cdsa_pkg::REQ_SET;
   localparam logic OP_ADD = cdsa_pkg::REQ_ADD;

   typedef struct packed {
      logic                           kind;
      logic [cdsa_pkg::DAY_W-1:0]     day;
      logic [cdsa_pkg::MONTH_W-1:0]   month;
      logic [cdsa_pkg::YEAR_W-1:0]    year;
      logic [cdsa_pkg::OFFSET_W-1:0]  offset;
   } date_req_type;

   typedef struct packed {
      logic [cdsa_pkg::DAY_W-1:0]     day;
      logic [cdsa_pkg::MONTH_W-1:0]   month;
      logic [cdsa_pkg::YEAR_W-1:0]    year;
      logic                           rejected;
   } date_rsp_type;

   typedef struct packed {
      date_req_type req;
      logic         fixed;
      date_rsp_type rsp;
   } table_row_type;

   localparam date_rsp_type ANY_RSP = '{5'd0, 4'd0, 14'd0, 1'b0};

   localparam table_row_type DIRECTED_ROWS [27] = '{
      '{'{OP_ADD, 5'd0,  4'd0,  14'd0,     16'sh0000}, 1'b1, '{5'd1,  4'd1,  14'd2000, 1'b0}},
      '{'{OP_SET, 5'd29, 4'd2,  14'd2000,  16'sh0000}, 1'b1, '{5'd29, 4'd2,  14'd2000, 1'b0}},
      '{'{OP_SET, 5'd29, 4'd2,  14'd1900,  16'sh0000}, 1'b1, '{5'd29, 4'd2,  14'd2000, 1'b1}},
      '{'{OP_SET, 5'd29, 4'd2,  14'd2004,  16'sh0000}, 1'b1, '{5'd29, 4'd2,  14'd2004, 1'b0}},
      '{'{OP_SET, 5'd0,  4'd5,  14'd2020,  16'sh0000}, 1'b1, '{5'd29, 4'd2,  14'd2004, 1'b1}},
      '{'{OP_SET, 5'd31, 4'd4,  14'd2020,  16'sh0000}, 1'b1, '{5'd29, 4'd2,  14'd2004, 1'b1}},
      '{'{OP_SET, 5'd15, 4'd0,  14'd2020,  16'sh0000}, 1'b1, '{5'd29, 4'd2,  14'd2004, 1'b1}},
      '{'{OP_SET, 5'd15, 4'd13, 14'd2020,  16'sh0000}, 1'b1, '{5'd29, 4'd2,  14'd2004, 1'b1}},
      '{'{OP_SET, 5'd15, 4'd15, 14'd2020,  16'sh0000}, 1'b1, '{5'd29, 4'd2,  14'd2004, 1'b1}},
      '{'{OP_SET, 5'd1,  4'd1,  14'd10000, 16'sh0000}, 1'b1, '{5'd29, 4'd2,  14'd2004, 1'b1}},
      '{'{OP_SET, 5'd31, 4'd15, 14'd16383, 16'sh0000}, 1'b1, '{5'd29, 4'd2,  14'd2004, 1'b1}},
      '{'{OP_SET, 5'd31, 4'd12, 14'd9999,  16'sh0000}, 1'b1, '{5'd31, 4'd12, 14'd9999, 1'b0}},
      '{'{OP_ADD, 5'd0,  4'd0,  14'd0,     16'sh0001}, 1'b1, '{5'd31, 4'd12, 14'd9999, 1'b1}},
      '{'{OP_ADD, 5'd0,  4'd0,  14'd0,     16'shffff}, 1'b1, '{5'd30, 4'd12, 14'd9999, 1'b0}},
      '{'{OP_SET, 5'd1,  4'd1,  14'd0,     16'sh0000}, 1'b1, '{5'd1,  4'd1,  14'd0,    1'b0}},
      '{'{OP_ADD, 5'd0,  4'd0,  14'd0,     16'shffff}, 1'b1, '{5'd1,  4'd1,  14'd0,    1'b1}},
      '{'{OP_SET, 5'd29, 4'd2,  14'd0,     16'sh0000}, 1'b1, '{5'd29, 4'd2,  14'd0,    1'b0}},
      '{'{OP_ADD, 5'd0,  4'd0,  14'd0,     16'sh7fff}, 1'b0, ANY_RSP},
      '{'{OP_ADD, 5'd0,  4'd0,  14'd0,     16'sh8000}, 1'b0, ANY_RSP},
      '{'{OP_SET, 5'd28, 4'd2,  14'd2023,  16'sh7fff}, 1'b1, '{5'd28, 4'd2,  14'd2023, 1'b0}},
      '{'{OP_ADD, 5'd0,  4'd0,  14'd0,     16'sh0001}, 1'b1, '{5'd1,  4'd3,  14'd2023, 1'b0}},
      '{'{OP_SET, 5'd28, 4'd2,  14'd2024,  16'sh0000}, 1'b1, '{5'd28, 4'd2,  14'd2024, 1'b0}},
      '{'{OP_ADD, 5'd0,  4'd0,  14'd0,     16'sh0001}, 1'b1, '{5'd29, 4'd2,  14'd2024, 1'b0}},
      '{'{OP_ADD, 5'd31, 4'd15, 14'd16383, 16'sh0000}, 1'b1, '{5'd29, 4'd2,  14'd2024, 1'b0}},
      '{'{OP_SET, 5'd31, 4'd12, 14'd1999,  16'sh0000}, 1'b1, '{5'd31, 4'd12, 14'd1999, 1'b0}},
      '{'{OP_ADD, 5'd0,  4'd0,  14'd0,     16'sh0001}, 1'b1, '{5'd1,  4'd1,  14'd2000, 1'b0}},
      '{'{OP_ADD, 5'd0,  4'd0,  14'd0,     -16'sd366}, 1'b0, ANY_RSP}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   cdsa_req_if req_chan ();
   cdsa_rsp_if rsp_chan ();

   calendar_date_set_and_add_days_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #10 clock = ~clock;

   int           cal_day   = 1;
   int           cal_month = 1;
   int           cal_year  = 2000;
   date_rsp_type expected_dates [$];
   int           date_mismatches = 0;
   int           cycle_count = 0;
   int           rsp_hold = 0;
   bit           steady_tail = 1'b0;

   function automatic int month_length(int m, int y);
      if (m < 1 || m > 12) return 0;
      if (m == 2) return ((y % 400 == 0) || (y % 4 == 0 && y % 100 != 0)) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
   endfunction

   function automatic date_rsp_type next_date(date_req_type r);
      int           d;
      int           m;
      int           y;
      int           raw;
      bit           bad;
      date_rsp_type res;
      bad = 1'b0;
      if (r.kind == cdsa_pkg::REQ_SET) begin
         d = r.day;
         m = r.month;
         y = r.year;
         if (y <= cdsa_pkg::MAX_YEAR && month_length(m, y) > 0 && d >= 1
             && d <= month_length(m, y)) begin
            cal_day = d;
            cal_month = m;
            cal_year = y;
         end else begin
            bad = 1'b1;
         end
      end else begin
         raw = int'(r.offset) & ((1 << cdsa_pkg::OFFSET_BITS) - 1);
         if (raw >= (1 << (cdsa_pkg::OFFSET_BITS - 1))) raw = raw - (1 << cdsa_pkg::OFFSET_BITS);
         d = cal_day + raw;
         m = cal_month;
         y = cal_year;
         while (!bad && d > month_length(m, y)) begin
            d = d - month_length(m, y);
            m++;
            if (m > 12) begin
               m = 1;
               y++;
               if (y > cdsa_pkg::MAX_YEAR) bad = 1'b1;
            end
         end
         while (!bad && d < 1) begin
            m--;
            if (m < 1) begin
               m = 12;
               y--;
            end
            if (y < 0) bad = 1'b1;
            else d = d + month_length(m, y);
         end
         if (!bad) begin
            cal_day = d;
            cal_month = m;
            cal_year = y;
         end
      end
      res.day = cdsa_pkg::DAY_W'(cal_day);
      res.month = cdsa_pkg::MONTH_W'(cal_month);
      res.year = cdsa_pkg::YEAR_W'(cal_year);
      res.rejected = bad;
      return res;
   endfunction

   function automatic date_req_type random_request();
      date_req_type r;
      int           pick;
      int           span;
      r.kind = cdsa_pkg::REQ_ADD;
      r.day = cdsa_pkg::DAY_W'($urandom);
      r.month = cdsa_pkg::MONTH_W'($urandom);
      r.year = cdsa_pkg::YEAR_W'($urandom_range(0, 16383));
      r.offset = cdsa_pkg::OFFSET_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         r.kind = cdsa_pkg::REQ_SET;
         case ($urandom_range(0, 3))
            0: r.year = cdsa_pkg::YEAR_W'($urandom_range(0, 40));
            1: r.year = cdsa_pkg::YEAR_W'($urandom_range(cdsa_pkg::MAX_YEAR - 40,
                                                        cdsa_pkg::MAX_YEAR));
            default: r.year = cdsa_pkg::YEAR_W'($urandom_range(0, cdsa_pkg::MAX_YEAR));
         endcase
         r.month = cdsa_pkg::MONTH_W'($urandom_range(1, 12));
         r.day = cdsa_pkg::DAY_W'($urandom_range(1, month_length(r.month, r.year)));
      end else if (pick < 42) begin
         r.kind = cdsa_pkg::REQ_SET;
      end else begin
         span = $urandom_range(0, 19);
         if (span < 6)
            r.offset = cdsa_pkg::OFFSET_W'(int'($urandom_range(0, 62)) - 31);
         else if (span < 12)
            r.offset = cdsa_pkg::OFFSET_W'(int'($urandom_range(0, 800)) - 400);
         else if (span < 17)
            r.offset = cdsa_pkg::OFFSET_W'(int'($urandom_range(0, 10000)) - 5000);
         else if (span == 17)
            r.offset = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      return r;
   endfunction

   task automatic send_word(input date_req_type r, input logic fixed,
                            input date_rsp_type fixed_rsp);
      date_rsp_type predicted;
      if (!steady_tail && $urandom_range(0, 3) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.req_type = r.kind;
      req_chan.new_day = r.day;
      req_chan.new_month = r.month;
      req_chan.new_year = r.year;
      req_chan.day_offset = r.offset;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      predicted = next_date(r);
      expected_dates.push_back(fixed ? fixed_rsp : predicted);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_chan.ready = 1'b0;
         rsp_hold--;
      end else if (!steady_tail && !reset && $urandom_range(0, 7) == 0) begin
         rsp_chan.ready = 1'b0;
         rsp_hold = $urandom_range(1, 19) - 1;
      end else begin
         rsp_chan.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      date_rsp_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_dates.size() == 0) begin
            date_mismatches++;
            if (date_mismatches <= 10)
               $display("unexpected response word: %0d-%0d-%0d rejected %b",
                        rsp_chan.cur_year, rsp_chan.cur_month, rsp_chan.cur_day,
                        rsp_chan.rejected);
         end else begin
            want = expected_dates.pop_front();
            if (rsp_chan.cur_day !== want.day || rsp_chan.cur_month !== want.month ||
                rsp_chan.cur_year !== want.year || rsp_chan.rejected !== want.rejected) begin
               date_mismatches++;
               if (date_mismatches <= 10)
                  $display("mismatch: want %0d-%0d-%0d rej %b, got %0d-%0d-%0d rej %b",
                           want.year, want.month, want.day, want.rejected,
                           rsp_chan.cur_year, rsp_chan.cur_month, rsp_chan.cur_day,
                           rsp_chan.rejected);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("calendar_date_set_and_add_days_core test failed");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.req_type = cdsa_pkg::REQ_SET;
      req_chan.new_day = '0;
      req_chan.new_month = '0;
      req_chan.new_year = '0;
      req_chan.day_offset = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (DIRECTED_ROWS[i])
         send_word(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].rsp);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n >= RANDOM_WORDS - STEADY_WORDS) steady_tail = 1'b1;
         send_word(random_request(), 1'b0, ANY_RSP);
      end
      req_chan.valid = 1'b0;
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (date_mismatches == 0 && expected_dates.size() == 0) begin
         $display("calendar_date_set_and_add_days_core test passed");
      end else begin
         $display("calendar_date_set_and_add_days_core test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/cdsa_pkg.sv
rtl/core/cdsa_chan_if.sv
rtl/core/calendar_date_set_and_add_days_core.sv
rtl/core/cdsa_checker.sv
tb/calendar_date_set_and_add_days_core_test.sv
